FILE: src/smd_pkg.sv
// Shared types and constants for the sign-magnitude restoring divider.
package smd_pkg;

    // Width of the magnitude fields on the block's ports.
    localparam int FIELD_W = 64;

    // Default operand width used by the arithmetic.
    localparam int DEFAULT_WIDTH = 64;

    // Sequencer states of the iterative divide unit.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } smd_state_t;

    // Controls from the top level to the divide unit.
    typedef struct packed {
        logic start;
        logic take;
    } smd_ctrl_t;

    // Status from the divide unit to the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } smd_stat_t;

endpackage

FILE: src/smd_core.sv
// Iterative restoring divide unit producing one quotient bit per cycle.
module smd_core
    import smd_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  smd_ctrl_t        ctrl,
    output smd_stat_t        stat,
    input  logic [WIDTH-1:0] dividend,
    input  logic             dividend_neg,
    input  logic [WIDTH-1:0] divisor,
    input  logic             divisor_neg,
    output logic [WIDTH-1:0] quotient,
    output logic             quotient_neg,
    output logic             divide_by_zero
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    smd_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] div_reg, div_next;
    logic             sign_reg, sign_next;
    logic             dz_reg, dz_next;

    logic             load_en;
    logic             step_en;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   rem_diff;
    logic             fits;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ctrl.take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        stat.idle = (state_reg == ST_IDLE);
        stat.done = (state_reg == ST_DONE);
        load_en   = (state_reg == ST_IDLE) && ctrl.start;
        step_en   = (state_reg == ST_RUN);
    end

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        fits      = !rem_diff[WIDTH];
    end

    // Datapath next values.
    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        sign_next = sign_reg;
        dz_next   = dz_reg;
        if (load_en) begin
            cnt_next  = CNT_W'(WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
            sign_next = dividend_neg ^ divisor_neg;
            dz_next   = (divisor == '0);
        end else if (step_en) begin
            cnt_next = cnt_reg - CNT_W'(1);
            rem_next = fits ? rem_diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        sign_reg <= sign_next;
        dz_reg   <= dz_next;
    end

    // A zero divisor forces a plus zero; a zero quotient is always plus.
    always_comb begin
        quotient       = dz_reg ? '0 : quo_reg;
        quotient_neg   = !dz_reg && sign_reg && (quo_reg != '0);
        divide_by_zero = dz_reg;
    end

endmodule

FILE: src/sign_magnitude_restoring_divider.sv
// Top level of the sign-magnitude restoring divider with its output register.
//
// The block divides two sign-magnitude integers and returns the truncated
// quotient of the magnitudes with its sign. Only the low WIDTH bits of each
// magnitude take part. An item enters on the s_ channel and its result leaves
// on the m_ channel; both use valid and ready.
// A nonzero quotient takes the XOR of the signs, a zero quotient is plus, and
// a zero divisor raises m_divide_by_zero with a plus zero quotient.
// The result passes from the divide unit's run and done states into the output
// register. The divide unit makes one quotient bit per cycle in a shared
// subtractor and works on one item at a time.
// A finished result waits in the output register while the divide unit
// accepts and works on the next item. If the receiver stalls, the unit holds
// its finished result until the output register frees up, and s_ready stays
// low meanwhile.
// Reset is synchronous and active low; it empties the output register and
// returns the divide unit to idle.
module sign_magnitude_restoring_divider
    import smd_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_dividend_mag,
    input  logic               s_dividend_neg,
    input  logic [FIELD_W-1:0] s_divisor_mag,
    input  logic               s_divisor_neg,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_quotient_mag,
    output logic               m_quotient_neg,
    output logic               m_divide_by_zero
);

    smd_ctrl_t          ctrl;
    smd_stat_t          stat;
    logic [WIDTH-1:0]   core_quotient;
    logic               core_neg;
    logic               core_dz;

    logic               m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0] m_quotient_mag_reg;
    logic               m_quotient_neg_reg;
    logic               m_divide_by_zero_reg;

    // Handshake with the divide unit.
    always_comb begin
        s_ready    = stat.idle;
        ctrl.start = s_valid && stat.idle;
        ctrl.take  = stat.done && (!m_valid_reg || m_ready);
    end

    smd_core #(
        .WIDTH(WIDTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .stat           (stat),
        .dividend       (s_dividend_mag[WIDTH-1:0]),
        .dividend_neg   (s_dividend_neg),
        .divisor        (s_divisor_mag[WIDTH-1:0]),
        .divisor_neg    (s_divisor_neg),
        .quotient       (core_quotient),
        .quotient_neg   (core_neg),
        .divide_by_zero (core_dz)
    );

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register payload, loaded when a finished result moves over.
    always_ff @(posedge aclk) begin
        if (ctrl.take) begin
            m_quotient_mag_reg   <= FIELD_W'(core_quotient);
            m_quotient_neg_reg   <= core_neg;
            m_divide_by_zero_reg <= core_dz;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_quotient_mag   = m_quotient_mag_reg;
    assign m_quotient_neg   = m_quotient_neg_reg;
    assign m_divide_by_zero = m_divide_by_zero_reg;

endmodule
